FILE: hdl/robin_hood_hash_table_top_defines.svh
// Assertion macros shared by the checker.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define RHHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RHHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rhht_pkg.sv
package rhht_pkg;

	localparam int ENTRY_COUNT_W = 11;
	localparam int LIMIT_W = 10;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd768;

	localparam logic [1:0] REQ_PUT = 2'd0;
	localparam logic [1:0] REQ_GET = 2'd1;
	localparam logic [1:0] REQ_DEL = 2'd2;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_DELETED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [47:0] hash;
		logic [63:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic [31:0]                value_out;
		logic [ENTRY_COUNT_W-1:0]   entry_count;
	} rsp_t;

	typedef struct packed {
		logic [47:0] hash;
		logic [63:0] key;
		logic [31:0] value;
	} entry_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_FIND,
		CMD_REPLACE,
		CMD_INS_ISSUE,
		CMD_INS,
		CMD_DEL_ISSUE,
		CMD_DEL,
		CMD_RESULT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic [1:0] in_type;
		logic [1:0] req_type;
		logic       hit;
		logic       miss;
		logic       full;
		logic       ins_end;
		logic       del_end;
		logic       out_busy;
	} sts_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_REPL,
		S_INS_RD,
		S_INS,
		S_DEL_RD,
		S_DEL,
		S_DONE
	} state_t;

endpackage

FILE: hdl/robin_hood_hash_table_top.sv
// Robin Hood hash table, one request at a time. After reset the slot store is
// swept clear, one slot per cycle, with req_stall high; cfg_valid limit writes
// are taken throughout. A request then passes through an accept step, the
// lookup reading one slot per cycle from the slot RAM (one read and one write
// port) over the P slots it probes, and a result step that loads the response
// register. An insert or a delete adds an issue step and a walk over the R
// slots it moves. A get hitting its home slot goes through accept, a single
// lookup step and the result step. The result step waits while a previous
// response is still stalled.
module robin_hood_hash_table_top #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  rhht_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output rhht_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rhht_pkg::LIMIT_W-1:0] cfg_data
);
	import rhht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rhht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rhht_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: hdl/rhht_ram.sv
module rhht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/rhht_dp.sv
module rhht_dp #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rhht_pkg::cmd_t          cmd,
	output rhht_pkg::sts_t          sts,
	input  rhht_pkg::req_t          req,
	input  logic                    rsp_stall,
	output logic                    rsp_valid,
	output rhht_pkg::rsp_t          rsp,
	input  logic                    cfg_valid,
	input  logic [rhht_pkg::LIMIT_W-1:0] cfg_data
);
	import rhht_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int DW = AW + 1;
	localparam int CW = AW + 1;
	localparam int EW = $bits(entry_t);
	localparam int WW = DW + EW;
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic             wen;
	logic [AW-1:0]    waddr, raddr;
	logic [WW-1:0]    wdata, rdata;
	logic [DW-1:0]    rd_dist;
	entry_t           rd_ent;

	req_t             req_q;
	logic [AW-1:0]    pos_q, clr_q, n_q;
	logic [DW-1:0]    dist_q, hit_dist_q;
	entry_t           car_q, ent_q;
	logic [CW-1:0]    count_q;
	logic [LIMIT_W-1:0] limit_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             match;
	logic [LW-1:0]    lim_ext, lim_cap, lim;
	logic [AW-1:0]    pos_inc;

	rhht_ram #(.WIDTH(WW), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_dist = rdata[WW-1 -: DW];
	assign rd_ent  = entry_t'(rdata[EW-1:0]);
	assign pos_inc = pos_q + AW'(1);
	assign match   = (rd_dist != '0) && (rd_ent.hash == req_q.hash)
		&& (rd_ent.key == req_q.key);

	assign lim_ext = LW'(limit_q);
	assign lim_cap = LW'(TABLE_SLOTS - 1);
	assign lim     = (lim_ext > lim_cap) ? lim_cap : lim_ext;

	always_comb begin
		sts.clear_done = (clr_q == '1);
		sts.in_type    = req.req_type;
		sts.req_type   = req_q.req_type;
		sts.hit        = match;
		sts.miss       = !match && ((rd_dist == '0) || (n_q == '1));
		sts.full       = (LW'(count_q) >= lim);
		sts.ins_end    = (rd_dist == '0);
		sts.del_end    = (rd_dist <= DW'(1));
		sts.out_busy   = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		wen   = 1'b0;
		waddr = pos_q;
		wdata = '0;
		raddr = pos_inc;
		unique case (cmd.op)
			CMD_CLEAR: begin
				wen   = 1'b1;
				waddr = clr_q;
			end
			CMD_ACCEPT:    raddr = req.hash[AW-1:0];
			CMD_INS_ISSUE: raddr = req_q.hash[AW-1:0];
			CMD_DEL_ISSUE: raddr = pos_inc;
			CMD_REPLACE: begin
				wen   = 1'b1;
				wdata = {hit_dist_q, ent_q.hash, ent_q.key, req_q.value};
			end
			CMD_INS: begin
				wen   = (rd_dist == '0) || (rd_dist < dist_q);
				wdata = {dist_q, car_q};
			end
			CMD_DEL: begin
				wen   = 1'b1;
				wdata = (rd_dist <= DW'(1)) ? '0 : {rd_dist - DW'(1), rd_ent};
				raddr = pos_q + AW'(2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_ACCEPT: begin
				req_q <= req;
				pos_q <= req.hash[AW-1:0];
				n_q   <= '0;
			end
			CMD_FIND: begin
				if (match) begin
					ent_q      <= rd_ent;
					hit_dist_q <= rd_dist;
				end else begin
					pos_q <= pos_inc;
					n_q   <= n_q + AW'(1);
				end
			end
			CMD_INS_ISSUE: begin
				pos_q  <= req_q.hash[AW-1:0];
				dist_q <= DW'(1);
				car_q  <= '{hash: req_q.hash, key: req_q.key, value: req_q.value};
			end
			CMD_INS: begin
				pos_q <= pos_inc;
				if (rd_dist != '0 && rd_dist < dist_q) begin
					car_q  <= rd_ent;
					dist_q <= rd_dist + DW'(1);
				end else begin
					dist_q <= dist_q + DW'(1);
				end
			end
			CMD_DEL: pos_q <= pos_inc;
			default: ;
		endcase
		if (cmd.op == CMD_RESULT) begin
			rsp_q.status <= cmd.code;
			case (cmd.code) inside
				ST_FOUND, ST_REPLACED, ST_DELETED: rsp_q.value_out <= ent_q.value;
				default: rsp_q.value_out <= '0;
			endcase
			rsp_q.entry_count <= ENTRY_COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == CMD_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.op == CMD_INS && rd_dist == '0) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.op == CMD_DEL_ISSUE && count_q != '0) begin
				count_q <= count_q - CW'(1);
			end
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.op == CMD_RESULT) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hdl/rhht_ctrl.sv
module rhht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rhht_pkg::sts_t sts,
	output rhht_pkg::cmd_t cmd
);
	import rhht_pkg::*;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_NOT_FOUND;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = CMD_NONE;
		cmd.code = code_q;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = CMD_CLEAR;
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = CMD_ACCEPT;
					if (sts.in_type == REQ_PUT || sts.in_type == REQ_GET
						|| sts.in_type == REQ_DEL) begin
						state_d = S_FIND;
					end else begin
						code_d  = ST_NOT_FOUND;
						state_d = S_DONE;
					end
				end
			end
			S_FIND: begin
				cmd.op = CMD_FIND;
				if (sts.hit) begin
					if (sts.req_type == REQ_PUT) begin
						state_d = S_REPL;
					end else if (sts.req_type == REQ_DEL) begin
						state_d = S_DEL_RD;
					end else begin
						code_d  = ST_FOUND;
						state_d = S_DONE;
					end
				end else if (sts.miss) begin
					if (sts.req_type == REQ_PUT && !sts.full) begin
						state_d = S_INS_RD;
					end else begin
						code_d  = (sts.req_type == REQ_PUT) ? ST_FULL : ST_NOT_FOUND;
						state_d = S_DONE;
					end
				end
			end
			S_REPL: begin
				cmd.op  = CMD_REPLACE;
				code_d  = ST_REPLACED;
				state_d = S_DONE;
			end
			S_INS_RD: begin
				cmd.op  = CMD_INS_ISSUE;
				state_d = S_INS;
			end
			S_INS: begin
				cmd.op = CMD_INS;
				if (sts.ins_end) begin
					code_d  = ST_INSERTED;
					state_d = S_DONE;
				end
			end
			S_DEL_RD: begin
				cmd.op  = CMD_DEL_ISSUE;
				state_d = S_DEL;
			end
			S_DEL: begin
				cmd.op = CMD_DEL;
				if (sts.del_end) begin
					code_d  = ST_DELETED;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.op  = CMD_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hdl/rhht_chk.sv
`include "robin_hood_hash_table_top_defines.svh"

module rhht_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rhht_pkg::rsp_t rsp
);
	import rhht_pkg::*;

	`RHHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp dropped")
	`RHHT_ASSERT_NOW(a_ins_count, rsp_valid && rsp.status == ST_INSERTED, rsp.entry_count != '0, "insert with zero count")
	`RHHT_ASSERT_NOW(a_miss_zero, rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL || rsp.status == ST_INSERTED), rsp.value_out == '0, "value on miss")
	`RHHT_ASSERT_NEXT(a_one_busy, req_valid && !req_stall, req_stall, "second transaction accepted")

endmodule

bind robin_hood_hash_table_top rhht_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
